>>> hdl/prc_pkg.sv
// Shared constants for the PWM prescaler / reload calculator.
package prc_pkg;

	localparam int COUNTER_BITS_DEF = 16;

	// Field widths
	localparam int FREQ_W = 27;
	localparam int DUTY_W = 7;
	localparam int PSC_W  = 11;
	localparam int ARR_W  = 16;
	localparam int CMP_W  = 17;

	// Internal widths
	localparam int DEN_W  = 28;  // f * (psc + 1), never above the clock rate
	localparam int NUM2_W = 29;  // 2 * clock + den, and 2 * den
	localparam int PROD_W = 36;  // (reload + 1) * duty

	// Divide by 100: drop two bits, then multiply by ceil(2^36 / 25)
	localparam int QN_W   = 31;  // product / 4, below 2^31
	localparam int RCP_W  = 32;
	localparam int RCP_SH = 36;
	localparam logic [RCP_W-1:0] RECIP_25 = 32'd2748779070;

	localparam logic [FREQ_W-1:0] CLK_HZ   = FREQ_W'(80000000);
	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

endpackage

>>> hdl/prc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module prc_div #(
	parameter int NUM_W  = 27,
	parameter int DEN_W  = 27,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s [0:NUM_W];
	logic [DEN_W-1:0]  rem_s [0:NUM_W];
	logic [NUM_W-1:0]  nq_s  [0:NUM_W];
	logic [DEN_W-1:0]  dv_s  [0:NUM_W];
	logic [SIDE_W-1:0] sd_s  [0:NUM_W];

	// stage 0 is the input
	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign dv_s[0]  = den;
	assign sd_s[0]  = side_in;

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;

		// shift in the next numerator bit and try a subtract
		assign trial = {rem_s[g], nq_s[g][NUM_W-1]};
		assign ge    = trial >= {1'b0, dv_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? DEN_W'(trial - {1'b0, dv_s[g]}) : trial[DEN_W-1:0];
			nq_s[g+1]  <= {nq_s[g][NUM_W-2:0], ge};
			dv_s[g+1]  <= dv_s[g];
			sd_s[g+1]  <= sd_s[g];
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = nq_s[NUM_W];
	assign side_out  = sd_s[NUM_W];

endmodule

>>> hdl/pwm_prescaler_reload_calculator.sv
// Top level of the PWM prescaler / reload / compare calculator.
//
// Usage: drive target_freq_hz and duty_percent and pulse start; a transaction
// is taken at every clock edge with start high and busy low. busy stays low,
// so a new transaction may be offered in every cycle.
// Each transaction gives one result, shown for one cycle with done high:
// prescale_value, reload_value, compare_value and period_valid.
// The pipeline has 62 register stages. Two bit-serial divider pipelines
// (27 and 29 stages) make up most of them; six further register stages hold
// the clamp, the prescaler, the divisor product, the duty product, the divide
// by 100 and the outputs. Throughput is one transaction per cycle.
// The clock is taken as 80 MHz; duty above 100 is clamped to 100 and a
// frequency above the clock is clamped to it. Frequency zero gives all zero
// fields with period_valid low.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall, so results are never held back.
module pwm_prescaler_reload_calculator #(
	parameter int COUNTER_BITS = prc_pkg::COUNTER_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [prc_pkg::FREQ_W-1:0]  target_freq_hz,
	input  logic [prc_pkg::DUTY_W-1:0]  duty_percent,
	output logic                        done,
	output logic [prc_pkg::PSC_W-1:0]   prescale_value,
	output logic [prc_pkg::ARR_W-1:0]   reload_value,
	output logic [prc_pkg::CMP_W-1:0]   compare_value,
	output logic                        period_valid
);
	import prc_pkg::*;

	localparam int SIDE1_W = FREQ_W + DUTY_W + 1;
	localparam int MUL_W   = QN_W + RCP_W;

	assign busy = 1'b0;

	// stage 1: clamp
	logic              v_s1, zero_s1;
	logic [FREQ_W-1:0] f_s1;
	logic [DUTY_W-1:0] duty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		f_s1    <= (target_freq_hz > CLK_HZ) ? CLK_HZ : target_freq_hz;
		duty_s1 <= (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;
		zero_s1 <= (target_freq_hz == '0);
	end

	// divider 1: (clock - 1) / f, prescaler is its top bits
	logic               v_d1;
	logic [FREQ_W-1:0]  q1;
	logic [SIDE1_W-1:0] sd1;

	prc_div #(.NUM_W(FREQ_W), .DEN_W(FREQ_W), .SIDE_W(SIDE1_W)) u_div_psc (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1),
		.num(CLK_HZ - FREQ_W'(1)),
		.den(zero_s1 ? FREQ_W'(1) : f_s1),
		.side_in({f_s1, duty_s1, zero_s1}),
		.out_valid(v_d1), .quo(q1), .side_out(sd1)
	);

	// stage 2: prescaler
	logic              v_s2, zero_s2;
	logic [FREQ_W-1:0] f_s2, psc_s2;
	logic [DUTY_W-1:0] duty_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		psc_s2                     <= q1 >> COUNTER_BITS;
		{f_s2, duty_s2, zero_s2}   <= sd1;
	end

	// stage 3: divisor f * (psc + 1)
	logic              v_s3, zero_s3;
	logic [DEN_W-1:0]  den_s3;
	logic [FREQ_W-1:0] psc_s3;
	logic [DUTY_W-1:0] duty_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3  <= DEN_W'(DEN_W'(f_s2) * (DEN_W'(psc_s2) + DEN_W'(1)));
		psc_s3  <= psc_s2;
		duty_s3 <= duty_s2;
		zero_s3 <= zero_s2;
	end

	// divider 2: round-half-up of clock / den
	logic               v_d2;
	logic [NUM2_W-1:0]  q2;
	logic [SIDE1_W-1:0] sd2;

	prc_div #(.NUM_W(NUM2_W), .DEN_W(NUM2_W), .SIDE_W(SIDE1_W)) u_div_arr (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3),
		.num(NUM2_W'({CLK_HZ, 1'b0}) + NUM2_W'(den_s3)),
		.den(zero_s3 ? NUM2_W'(2) : NUM2_W'({den_s3, 1'b0})),
		.side_in({psc_s3, duty_s3, zero_s3}),
		.out_valid(v_d2), .quo(q2), .side_out(sd2)
	);

	// stage 5: reload and duty product
	logic              v_s5, zero_s5;
	logic [NUM2_W-1:0] arr_s5;
	logic [PROD_W-1:0] prod_s5;
	logic [FREQ_W-1:0] psc_s5;
	logic [DUTY_W-1:0] duty_d2;
	logic [FREQ_W-1:0] psc_d2;
	logic              zero_d2;

	assign {psc_d2, duty_d2, zero_d2} = sd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		arr_s5  <= q2 - NUM2_W'(1);
		prod_s5 <= PROD_W'(q2) * PROD_W'(duty_d2);
		psc_s5  <= psc_d2;
		zero_s5 <= zero_d2;
	end

	// stage 6: product / 100 as (product / 4) / 25 by reciprocal multiply
	logic             v_s6, zero_s6;
	logic [PSC_W-1:0] psc_s6;
	logic [ARR_W-1:0] arr_s6;
	logic [CMP_W-1:0] cmp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		cmp_s6  <= CMP_W'((MUL_W'(prod_s5[QN_W+1:2]) * MUL_W'(RECIP_25)) >> RCP_SH);
		psc_s6  <= psc_s5[PSC_W-1:0];
		arr_s6  <= arr_s5[ARR_W-1:0];
		zero_s6 <= zero_s5;
	end

	// output registers
	logic             done_q, pv_q;
	logic [PSC_W-1:0] psc_q;
	logic [ARR_W-1:0] arr_q;
	logic [CMP_W-1:0] cmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		psc_q <= zero_s6 ? '0 : psc_s6;
		arr_q <= zero_s6 ? '0 : arr_s6;
		cmp_q <= zero_s6 ? '0 : cmp_s6;
		pv_q  <= !zero_s6;
	end

	assign done           = done_q;
	assign prescale_value = psc_q;
	assign reload_value   = arr_q;
	assign compare_value  = cmp_q;
	assign period_valid   = pv_q;

endmodule

>>> hdl/prc_chk.sv
// Port checker for the PWM prescaler / reload calculator, with its bind.
module prc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [prc_pkg::PSC_W-1:0]   prescale_value,
	input logic [prc_pkg::ARR_W-1:0]   reload_value,
	input logic [prc_pkg::CMP_W-1:0]   compare_value,
	input logic                        period_valid
);
	import prc_pkg::*;

	// block never refuses a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// frequency zero gives all zero fields
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !period_valid |->
		prescale_value == '0 && reload_value == '0 && compare_value == '0)
		else $error("non-zero fields with period_valid low");

	// compare never exceeds one period
	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {1'b0, compare_value} <= {2'b00, reload_value} + 18'd1)
		else $error("compare beyond period");

	// the clock fits within the prescaler range
	a_psc_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> prescale_value <= PSC_W'(1220))
		else $error("prescaler out of range");

endmodule

bind pwm_prescaler_reload_calculator prc_chk u_prc_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.prescale_value(prescale_value), .reload_value(reload_value),
	.compare_value(compare_value), .period_valid(period_valid)
);
